// ===== rtl/jlgs_pkg.sv =====
package jlgs_pkg;

   localparam int DATA_W = 32;
   localparam int ERR_W  = 31;
   localparam int ITER_W = 24;
   localparam int CHK_W  = 16;
   localparam int SIZE_W = 8;
   localparam int OP_W   = 2;
   localparam int ADDR_W = 7;
   localparam int SUM_W  = 34;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam logic [1:0] REG_GRID_SIZE = 2'd0;
   localparam logic [1:0] REG_ACCURACY  = 2'd1;
   localparam logic [1:0] REG_MAX_ITER  = 2'd2;
   localparam logic [1:0] REG_CHK_INT   = 2'd3;

   // per-cell sequence steps
   localparam logic [2:0] PH_CENTER = 3'd0;
   localparam logic [2:0] PH_UP     = 3'd1;
   localparam logic [2:0] PH_DOWN   = 3'd2;
   localparam logic [2:0] PH_LEFT   = 3'd3;
   localparam logic [2:0] PH_RIGHT  = 3'd4;
   localparam logic [2:0] PH_LAST   = 3'd5;
   localparam logic [2:0] PH_WRITE  = 3'd6;
   localparam logic [2:0] PH_MAX    = 3'd7;

   localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESP,
      ST_SW_CHECK,
      ST_CELL,
      ST_SW_END
   } state_type;

endpackage

// ===== rtl/jacobi_laplace_grid_solver.sv =====
// Jacobi Laplace solver over a square grid held in two ping-pong memories.
// A write or read op is accepted when start is high and busy is low, and its
// result strobes on rsp_valid in the next cycle. A solve op runs sweeps
// through one shared accumulator under a per-cell sequencer: every sweep
// visits all MAX_SIDE*MAX_SIDE stored cells in turn (five memory reads
// through the single read port, a last accumulate, write, error update),
// with sweep bookkeeping in the ST_SW_CHECK and ST_SW_END states. The
// result strobe lasts one cycle and cannot be held off by the receiver;
// capture it when it comes.
module jacobi_laplace_grid_solver
   import jlgs_pkg::*;
#(
   parameter int MAX_SIDE  = 128,
   parameter int FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ADDR_W-1:0]        req_row,
   input  logic [ADDR_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0] req_cell_value,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [ITER_W-1:0]        rsp_iterations_done,
   output logic [ERR_W-1:0]         rsp_final_error,
   output logic                     rsp_converged,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [ERR_W-1:0]         csr_wdata
);

   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(MAX_SIDE);
   localparam int NW    = (RW + 2 > SIZE_W) ? RW + 2 : SIZE_W;
   localparam logic [ERR_W-1:0] ERR_ONE = ERR_W'(1) << FRAC_BITS;
   localparam logic [RW-1:0]    LAST_RC = RW'(MAX_SIDE - 1);

   logic [DATA_W-1:0] mem_even [CELLS];
   logic [DATA_W-1:0] mem_odd  [CELLS];

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] grid_size_ff;
   logic [ERR_W-1:0]  accuracy_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [CHK_W-1:0]  chk_int_ff;

   logic              latest_ff, latest_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [ERR_W-1:0]  error_ff, error_in;
   logic [CHK_W-1:0]  chk_cnt_ff, chk_cnt_in;
   logic [RW-1:0]     row_ff, row_in, col_ff, col_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [2:0]        ph_ff, ph_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0] center_ff, center_in;
   logic [DATA_W:0]   diff_ff, diff_in;
   logic [ERR_W-1:0]  maxd_ff, maxd_in;
   logic              rd_op_ff, rd_op_in, rd_inside_ff, rd_inside_in;

   logic [DATA_W-1:0] rd_even_ff, rd_odd_ff;

   logic              mem_we_even, mem_we_odd;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   logic              accept;
   logic              host_inside;
   logic [AW-1:0]     host_idx;
   logic [NW-1:0]     side_n, row_n, col_n;
   logic              interior;
   logic              last_cell;
   logic [DATA_W-1:0] src_data;
   logic [DATA_W-1:0] new_val;
   logic [DATA_W:0]   abs_diff;
   logic [ERR_W-1:0]  sat_diff;
   logic              sweep_go;
   logic              measure;
   logic              chk_hit;

   assign accept      = start && (state_ff == ST_IDLE);
   assign host_inside = (int'(req_row) < MAX_SIDE) && (int'(req_col) < MAX_SIDE);
   assign host_idx    = AW'(int'(req_row) * MAX_SIDE + int'(req_col));

   assign side_n    = (int'(grid_size_ff) > MAX_SIDE) ? NW'(MAX_SIDE) : NW'(grid_size_ff);
   assign row_n     = NW'(row_ff);
   assign col_n     = NW'(col_ff);
   assign interior  = (row_n != '0) && (row_n + NW'(1) < side_n) &&
                      (col_n != '0) && (col_n + NW'(1) < side_n);
   assign last_cell = (row_ff == LAST_RC) && (col_ff == LAST_RC);

   assign src_data = latest_ff ? rd_odd_ff : rd_even_ff;
   assign new_val  = acc_ff[SUM_W-1:2];   // floor of sum / 4
   assign abs_diff = diff_ff[DATA_W] ? (~diff_ff + 1'b1) : diff_ff;
   assign sat_diff = (abs_diff[DATA_W:ERR_W] != '0) ? ERR_MAX : abs_diff[ERR_W-1:0];

   assign sweep_go = (iter_ff < max_iter_ff) && (error_ff > accuracy_ff);
   assign chk_hit  = (chk_int_ff != '0) && (chk_cnt_ff == chk_int_ff);
   assign measure  = (iter_ff == '0) || chk_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op == OP_SOLVE) ? ST_SW_CHECK : ST_RESP;
            end
         end
         ST_SW_CHECK: state_in = sweep_go ? ST_CELL : ST_RESP;
         ST_CELL: begin
            if (ph_ff == PH_MAX && last_cell) begin
               state_in = ST_SW_END;
            end
         end
         ST_SW_END: state_in = ST_SW_CHECK;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      rsp_valid           = (state_ff == ST_RESP);
      rsp_read_value      = (rd_op_ff && rd_inside_ff) ? src_data : '0;
      rsp_iterations_done = iter_ff;
      rsp_final_error     = error_ff;
      rsp_converged       = (error_ff <= accuracy_ff);
   end

   // datapath and sequencer
   always_comb begin
      latest_in    = latest_ff;
      iter_in      = iter_ff;
      error_in     = error_ff;
      chk_cnt_in   = chk_cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      ph_in        = ph_ff;
      acc_in       = acc_ff;
      center_in    = center_ff;
      diff_in      = diff_ff;
      maxd_in      = maxd_ff;
      rd_op_in     = rd_op_ff;
      rd_inside_in = rd_inside_ff;
      mem_we_even  = 1'b0;
      mem_we_odd   = 1'b0;
      mem_raddr    = idx_ff;
      mem_waddr    = idx_ff;
      mem_wdata    = req_cell_value;

      case (state_ff)
         ST_IDLE: begin
            mem_raddr = host_idx;
            mem_waddr = host_idx;
            if (accept) begin
               rd_op_in     = (req_op == OP_READ);
               rd_inside_in = host_inside;
               if (req_op == OP_WRITE && host_inside) begin
                  mem_we_even = 1'b1;
                  mem_we_odd  = 1'b1;
               end
               if (req_op == OP_SOLVE) begin
                  iter_in    = '0;
                  error_in   = ERR_ONE;
                  chk_cnt_in = CHK_W'(1);
               end
            end
         end
         ST_SW_CHECK: begin
            row_in  = '0;
            col_in  = '0;
            idx_in  = '0;
            ph_in   = PH_CENTER;
            maxd_in = '0;
         end
         ST_CELL: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               PH_CENTER: mem_raddr = idx_ff;
               PH_UP: begin
                  if (interior) mem_raddr = idx_ff - AW'(MAX_SIDE);
                  center_in = src_data;
               end
               PH_DOWN: begin
                  if (interior) mem_raddr = idx_ff + AW'(MAX_SIDE);
                  acc_in = SUM_W'($signed(src_data));
               end
               PH_LEFT: begin
                  if (interior) mem_raddr = idx_ff - AW'(1);
                  acc_in = acc_ff + SUM_W'($signed(src_data));
               end
               PH_RIGHT: begin
                  if (interior) mem_raddr = idx_ff + AW'(1);
                  acc_in = acc_ff + SUM_W'($signed(src_data));
               end
               PH_LAST: acc_in = acc_ff + SUM_W'($signed(src_data));
               PH_WRITE: begin
                  mem_wdata   = interior ? new_val : center_ff;
                  mem_we_even = latest_ff;
                  mem_we_odd  = !latest_ff;
                  diff_in     = interior ?
                                ({new_val[DATA_W-1], new_val} -
                                 {center_ff[DATA_W-1], center_ff}) : '0;
               end
               PH_MAX: begin
                  if (sat_diff > maxd_ff) maxd_in = sat_diff;
                  idx_in = idx_ff + AW'(1);
                  if (col_ff == LAST_RC) begin
                     col_in = '0;
                     row_in = row_ff + RW'(1);
                  end else begin
                     col_in = col_ff + RW'(1);
                  end
               end
               default: ph_in = PH_CENTER;
            endcase
         end
         ST_SW_END: begin
            if (measure) error_in = maxd_ff;
            chk_cnt_in = chk_hit ? CHK_W'(1) : chk_cnt_ff + CHK_W'(1);
            iter_in    = iter_ff + ITER_W'(1);
            latest_in  = !latest_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we_even) mem_even[mem_waddr] <= mem_wdata;
      if (mem_we_odd)  mem_odd[mem_waddr]  <= mem_wdata;
      rd_even_ff <= mem_even[mem_raddr];
      rd_odd_ff  <= mem_odd[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         latest_ff    <= 1'b0;
         iter_ff      <= '0;
         error_ff     <= ERR_ONE;
         grid_size_ff <= SIZE_W'(128);
         accuracy_ff  <= ERR_W'(17);
         max_iter_ff  <= ITER_W'(1000000);
         chk_int_ff   <= CHK_W'(10000);
         ph_ff        <= PH_CENTER;
         rd_op_ff     <= 1'b0;
         rd_inside_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latest_ff    <= latest_in;
         iter_ff      <= iter_in;
         error_ff     <= error_in;
         ph_ff        <= ph_in;
         rd_op_ff     <= rd_op_in;
         rd_inside_ff <= rd_inside_in;
         if (csr_we) begin
            case (csr_index)
               REG_GRID_SIZE: grid_size_ff <= csr_wdata[SIZE_W-1:0];
               REG_ACCURACY:  accuracy_ff  <= csr_wdata;
               REG_MAX_ITER:  max_iter_ff  <= csr_wdata[ITER_W-1:0];
               REG_CHK_INT:   chk_int_ff   <= csr_wdata[CHK_W-1:0];
               default: ;
            endcase
         end
      end
      chk_cnt_ff <= chk_cnt_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      center_ff  <= center_in;
      diff_ff    <= diff_in;
      maxd_ff    <= maxd_in;
   end

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted op did not raise busy");

   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (iter_ff < max_iter_ff))
      else $error("sweep running past iteration cap");

   a_flip_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_END) |=> (latest_ff != $past(latest_ff)))
      else $error("buffer did not swap at sweep end");

endmodule
